[design/mtdm_pkg.sv]
// ----------------------------------------------------------------------------
// mtdm_pkg: shared types and constants of the multi-tap delay mixer
// Sizes, register indexes, mode codes and the front-to-back command format.
// ----------------------------------------------------------------------------
package mtdm_pkg;

    localparam int CHANNELS    = 2;
    localparam int DELAY_DEPTH = 65536;   // power of two: pointers wrap by truncation
    localparam int SAMPLE_BITS = 24;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W     = $clog2(DELAY_DEPTH);
    localparam int ADDR_W    = CH_W + PTR_W;
    localparam int MEM_DEPTH = (1 << CH_W) * DELAY_DEPTH;
    localparam int ACC_W     = SAMPLE_BITS + 2;

    localparam int DELAY_W   = 16;
    localparam int EXT_W     = ((PTR_W > DELAY_W) ? PTR_W : DELAY_W) + 1;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAP3   = 3'd4;

    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_MIX1 = 2'd1;
    localparam logic [1:0] MODE_MIX3 = 2'd2;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_FEED,
        OP_MIX1,
        OP_MIX3
    } op_t;

    typedef struct packed {
        op_t                          op;
        logic [CH_W-1:0]              ch;
        logic [PTR_W-1:0]             wr_idx;
        logic [2:0][PTR_W-1:0]        tap_idx;
        logic [2:0]                   tap_ok;
        logic [SAMPLE_BITS-1:0]       sample;
    } cmd_t;

    function automatic logic signed [ACC_W-1:0] sext(input logic [SAMPLE_BITS-1:0] v);
        return ACC_W'($signed(v));
    endfunction

endpackage

[design/mtdm_front.sv]
// ----------------------------------------------------------------------------
// mtdm_front: request intake and classification
// Holds the configuration and per-channel write pointers, turns each request
// into a memory command (tap addresses, write address, operation).
// ----------------------------------------------------------------------------
module mtdm_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             channel,
    input  logic signed [mtdm_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                             cfg_we,
    input  logic [mtdm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtdm_pkg::CFG_W-1:0]       cfg_data,
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output mtdm_pkg::cmd_t                   cmd
);
    import mtdm_pkg::*;

    logic [1:0]          mode_reg;
    logic                bypass_reg;
    logic [DELAY_W-1:0]  tap_delay_reg [3];
    logic [PTR_W-1:0]    wp_reg [CHANNELS];
    logic                full_reg [CHANNELS];

    logic                ch_ok;
    logic                feed;
    logic [CH_W-1:0]     ch_idx;
    logic [PTR_W-1:0]    wp;
    logic                full;
    logic                accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PASS;
            bypass_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                tap_delay_reg[k] <= DELAY_W'(1);
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg         <= cfg_data[1:0];
                REG_BYPASS: bypass_reg       <= cfg_data[0];
                REG_TAP1:   tap_delay_reg[0] <= cfg_data[DELAY_W-1:0];
                REG_TAP2:   tap_delay_reg[1] <= cfg_data[DELAY_W-1:0];
                REG_TAP3:   tap_delay_reg[2] <= cfg_data[DELAY_W-1:0];
                default:    ;
            endcase
        end
    end

    assign ch_ok  = (32'(channel) < CHANNELS);
    assign ch_idx = CH_W'(channel);
    assign wp     = wp_reg[ch_idx];
    assign full   = full_reg[ch_idx];
    assign feed   = ((mode_reg == MODE_MIX1) || (mode_reg == MODE_MIX3)) && ch_ok;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;

    always_comb
    begin
        cmd.ch     = ch_idx;
        cmd.wr_idx = wp;
        cmd.sample = sample_in;
        if (!feed)
            cmd.op = OP_PASS;
        else if (bypass_reg)
            cmd.op = OP_FEED;
        else if (mode_reg == MODE_MIX1)
            cmd.op = OP_MIX1;
        else
            cmd.op = OP_MIX3;
        for (int k = 0; k < 3; k++)
        begin
            // delay wraps modulo the store depth
            cmd.tap_idx[k] = PTR_W'(EXT_W'(wp) - EXT_W'(tap_delay_reg[k]));
            // slot never written yet reads as zero
            cmd.tap_ok[k]  = full || (cmd.tap_idx[k] < wp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                wp_reg[c]   <= '0;
                full_reg[c] <= 1'b0;
            end
        end
        else if (accept && feed)
        begin
            wp_reg[ch_idx] <= wp + PTR_W'(1);
            if (wp == PTR_W'(DELAY_DEPTH - 1))
                full_reg[ch_idx] <= 1'b1;
        end
    end

endmodule

[design/mtdm_fifo.sv]
// ----------------------------------------------------------------------------
// mtdm_fifo: command queue between front and back
// Small register FIFO so intake and memory sequencing stall independently.
// ----------------------------------------------------------------------------
module mtdm_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  mtdm_pkg::cmd_t   push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mtdm_pkg::cmd_t   pop_data
);
    import mtdm_pkg::*;

    localparam int QP_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t              slot_reg [FIFO_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg;
    logic [QP_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QP_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

[design/mtdm_back.sv]
// ----------------------------------------------------------------------------
// mtdm_back: memory sequencer and mixer
// Runs tap reads and the sample write on the single-port delay store,
// accumulates the taps and drives the output register.
// ----------------------------------------------------------------------------
module mtdm_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  mtdm_pkg::cmd_t                   cmd,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [mtdm_pkg::SAMPLE_BITS-1:0] sample_out
);
    import mtdm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_R1   = 6'b000010,
        ST_R2   = 6'b000100,
        ST_R3   = 6'b001000,
        ST_WR   = 6'b010000,
        ST_PASS = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      pend_reg, pend_next;
    logic                      pend_ok_reg, pend_ok_next;
    logic                      out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]    sample_out_reg, sample_out_next;

    logic [SAMPLE_BITS-1:0]    mem [MEM_DEPTH];
    logic [SAMPLE_BITS-1:0]    rd_data_reg;
    logic [ADDR_W-1:0]         mem_addr;
    logic                      mem_we;

    logic signed [ACC_W-1:0]   sum_now;
    logic [SAMPLE_BITS-1:0]    result;
    logic                      finishing;
    logic                      finish_fire;
    logic                      can_pop;
    logic                      pop;

    // single port: a write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= cmd_reg.sample;
        else
            rd_data_reg <= mem[mem_addr];
    end

    always_comb
    begin
        case (state_reg)
            ST_R1:   mem_addr = {cmd_reg.ch, cmd_reg.tap_idx[0]};
            ST_R2:   mem_addr = {cmd_reg.ch, cmd_reg.tap_idx[1]};
            ST_R3:   mem_addr = {cmd_reg.ch, cmd_reg.tap_idx[2]};
            default: mem_addr = {cmd_reg.ch, cmd_reg.wr_idx};
        endcase
    end
    assign mem_we = (state_reg == ST_WR);

    // fold in the tap read issued last cycle
    assign sum_now = acc_reg + ((pend_reg && pend_ok_reg) ? sext(rd_data_reg) : ACC_W'(0));

    always_comb
    begin
        case (cmd_reg.op)
            OP_MIX1: result = sum_now[SAMPLE_BITS:1];
            OP_MIX3: result = sum_now[SAMPLE_BITS+1:2];
            default: result = cmd_reg.sample;
        endcase
    end

    assign finishing   = (state_reg == ST_WR) || (state_reg == ST_PASS);
    assign finish_fire = finishing && (!out_valid_reg || out_ready);
    assign can_pop     = (state_reg == ST_IDLE) || finish_fire;
    assign cmd_ready   = can_pop;
    assign pop         = can_pop && cmd_valid;

    always_comb
    begin
        state_next   = state_reg;
        pend_next    = 1'b0;
        pend_ok_next = 1'b0;
        acc_next     = sum_now;
        case (state_reg)
            ST_R1:
            begin
                pend_next    = 1'b1;
                pend_ok_next = cmd_reg.tap_ok[0];
                state_next   = (cmd_reg.op == OP_MIX3) ? ST_R2 : ST_WR;
            end
            ST_R2:
            begin
                pend_next    = 1'b1;
                pend_ok_next = cmd_reg.tap_ok[1];
                state_next   = ST_R3;
            end
            ST_R3:
            begin
                pend_next    = 1'b1;
                pend_ok_next = cmd_reg.tap_ok[2];
                state_next   = ST_WR;
            end
            ST_WR, ST_PASS:
            begin
                if (finish_fire)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (pop)
        begin
            acc_next = sext(cmd.sample);
            case (cmd.op)
                OP_PASS: state_next = ST_PASS;
                OP_FEED: state_next = ST_WR;
                default: state_next = ST_R1;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        if (finish_fire)
        begin
            out_valid_next  = 1'b1;
            sample_out_next = result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        pend_ok_reg    <= pend_ok_next;
        sample_out_reg <= sample_out_next;
        if (pop)
            cmd_reg <= cmd;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE) || finish_fire)
        else $error("command popped while back end busy");

    a_pend_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ($past(state_reg) == ST_R1) || ($past(state_reg) == ST_R2)
                  || ($past(state_reg) == ST_R3))
        else $error("pending tap without a read issued");

    a_three_tap_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_R2) || (state_reg == ST_R3) |-> cmd_reg.op == OP_MIX3)
        else $error("extra tap read outside three-tap mode");

    a_finish_lands: assert property (@(posedge clk) disable iff (!rst_n)
        finish_fire |=> out_valid_reg)
        else $error("finished request did not reach output register");

    a_no_write_while_reading: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !pend_next)
        else $error("write overlaps a tap read");

endmodule

[design/multi_tap_delay_mixer_top.sv]
// ----------------------------------------------------------------------------
// multi_tap_delay_mixer_top: per-channel multi-tap audio delay mixer
// Input requests (channel, sample_in) and output requests (sample_out) use
// valid/ready; configuration goes through a plain write port (cfg_we,
// cfg_index, cfg_data), registers in order mode, bypass, tap1..tap3 delay.
// Registers may be written only while no request is in flight.
// Each input request gives exactly one output request, in order.
// Per request the back end drives the single-port delay memory (one access a
// cycle): three-tap mix reads three taps then writes, single-tap mix reads
// one tap then writes, bypass feed only writes, pass-through only forwards.
// A two-entry command queue sits between intake and memory sequencing and an
// output register holds the result; when the receiver stalls the back end
// holds at its final step and the queue keeps taking requests until full.
// Reset sets mode pass, bypass off, tap delays 1, clears write pointers and
// fill flags; unwritten slots read as zero: no memory clearing pass needed.
// ----------------------------------------------------------------------------
module multi_tap_delay_mixer_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             channel,
    input  logic signed [mtdm_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [mtdm_pkg::SAMPLE_BITS-1:0] sample_out,
    input  logic                             cfg_we,
    input  logic [mtdm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mtdm_pkg::CFG_W-1:0]       cfg_data
);
    import mtdm_pkg::*;

    cmd_t  push_cmd;
    cmd_t  pop_cmd;
    logic  push_valid;
    logic  push_ready;
    logic  pop_valid;
    logic  pop_ready;

    mtdm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .channel   (channel),
        .sample_in (sample_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (push_valid),
        .cmd_ready (push_ready),
        .cmd       (push_cmd)
    );

    mtdm_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_cmd)
    );

    mtdm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd        (pop_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for multi_tap_delay_mixer_top
// A directed table covers the corner cases of every mode first. Randomized
// configuration phases follow. A bit-accurate mirror of the per-channel delay
// lines predicts each output sample, and outputs are checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    import mtdm_pkg::*;

    localparam int         CLK_PERIOD   = 8;
    localparam int         RAND_ITEMS   = 1900;
    localparam int         STALL_LIMIT  = 5000;
    localparam int         DRAIN_CYCLES = 12;
    localparam int         MAX_REPORTS  = 10;
    localparam int         DIR_ROWS     = 39;
    localparam logic [1:0] MODE_SPARE   = 2'd3;   // code with no meaning: passes through

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t SMP_MIN = 24'h800000;
    localparam sample_t SMP_MAX = 24'h7FFFFF;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       val;
        logic                   ch;
        logic [SAMPLE_BITS-1:0] smp;
        logic                   has_want;
        logic [SAMPLE_BITS-1:0] want;
    } dir_row_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 channel     = 1'b0;
    sample_t              sample_in   = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b1;
    sample_t              sample_out;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;

    // typed-in expectation travelling with the request
    logic                 dir_want_on = 1'b0;
    sample_t              dir_want    = '0;

    // mirror of the block's registers and delay lines
    logic [1:0]             mode_m;
    logic                   bypass_m;
    logic [DELAY_W-1:0]     tap_delay_m [3];
    logic [SAMPLE_BITS-1:0] echo_mem [CHANNELS][DELAY_DEPTH];
    logic [PTR_W-1:0]       echo_wp [CHANNELS];

    sample_t pending_mix [$];

    int mismatches   = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int cfg_writes   = 0;
    int dir_items    = 0;
    int rand_sent    = 0;
    int bypass_fed   = 0;
    int rx_hold      = 0;
    int mode_hits [4] = '{0, 0, 0, 0};

    dir_row_t dir_tab [DIR_ROWS] = '{
        // after reset: pass-through at the extremes
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
        '{ROW_ITEM, REG_MODE,   '0,               1'b1, 24'h800000, 1'b1, 24'h800000},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'h000000, 1'b1, 24'h000000},
        '{ROW_CFG,  REG_MODE,   CFG_W'(MODE_SPARE), 1'b0, '0,       1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b1, 24'h5A5A5A, 1'b1, 24'h5A5A5A},
        '{ROW_CFG,  REG_BYPASS, 16'd1,            1'b0, '0,         1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{ROW_CFG,  REG_MODE,   CFG_W'(MODE_PASS), 1'b0, '0,        1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b1, 24'h12D687, 1'b1, 24'h12D687},
        // bypass in single-tap mode still fills the line
        '{ROW_CFG,  REG_MODE,   CFG_W'(MODE_MIX1), 1'b0, '0,        1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'h800000, 1'b1, 24'h800000},
        '{ROW_CFG,  REG_BYPASS, 16'd0,            1'b0, '0,         1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'h800000, 1'b1, 24'h800000},
        // -1 halved must floor to -1
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'h7FFFFF, 1'b1, 24'hFFFFFF},
        '{ROW_ITEM, REG_MODE,   '0,               1'b1, 24'h7FFFFF, 1'b1, 24'h3FFFFF},
        // zero delay reads the slot about to be written
        '{ROW_CFG,  REG_TAP1,   16'd0,            1'b0, '0,         1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'h7FFFFF, 1'b1, 24'h3FFFFF},
        '{ROW_CFG,  REG_TAP1,   16'hFFFF,         1'b0, '0,         1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b1, 24'h800000, 1'b1, 24'hC00000},
        '{ROW_CFG,  REG_TAP1,   16'd1,            1'b0, '0,         1'b0, '0},
        '{ROW_CFG,  REG_TAP2,   16'd2,            1'b0, '0,         1'b0, '0},
        '{ROW_CFG,  REG_TAP3,   16'd3,            1'b0, '0,         1'b0, '0},
        '{ROW_CFG,  REG_MODE,   CFG_W'(MODE_MIX3), 1'b0, '0,        1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'h7FFFFF, 1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'h800000, 1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b1, 24'h000001, 1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'hFFFFFF, 1'b0, '0},
        '{ROW_CFG,  REG_BYPASS, 16'd1,            1'b0, '0,         1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b1, 24'h400000, 1'b1, 24'h400000},
        '{ROW_CFG,  REG_BYPASS, 16'd0,            1'b0, '0,         1'b0, '0},
        '{ROW_CFG,  REG_TAP2,   16'hFFFF,         1'b0, '0,         1'b0, '0},
        '{ROW_CFG,  REG_TAP3,   16'd0,            1'b0, '0,         1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b1, 24'h2AAAAA, 1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'hD55555, 1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b1, 24'h800000, 1'b0, '0},
        '{ROW_CFG,  REG_MODE,   CFG_W'(MODE_MIX1), 1'b0, '0,        1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'h000001, 1'b0, '0},
        '{ROW_ITEM, REG_MODE,   '0,               1'b0, 24'hFFFFFF, 1'b0, '0}
    };

    multi_tap_delay_mixer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .channel    (channel),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // mostly zero, sometimes a few cycles, rarely a long hold
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(11))
            0:       return SMP_MIN;
            1:       return SMP_MAX;
            2:       return '0;
            3:       return '1;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // short delays keep the taps on data written in this run
    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return DELAY_W'($urandom_range(48, 1));
        if (r < 72)
            return DELAY_W'($urandom_range(1500, 49));
        if (r < 80)
            return '0;
        if (r < 88)
            return '1;
        return DELAY_W'($urandom);
    endfunction

    function automatic sample_t tap_value(input logic ch, input logic [DELAY_W-1:0] dly);
        logic [PTR_W-1:0] slot;
        slot = echo_wp[ch] - dly;
        return echo_mem[ch][slot];
    endfunction

    // output sample for one request; advances the delay line when fed
    function automatic sample_t mixed_sample(input logic ch, input sample_t x);
        logic signed [ACC_W-1:0] acc;
        sample_t                 y;
        y = x;
        if (mode_m == MODE_MIX1 || mode_m == MODE_MIX3) begin
            if (!bypass_m) begin
                if (mode_m == MODE_MIX1) begin
                    acc = ACC_W'(x) + ACC_W'(tap_value(ch, tap_delay_m[0]));
                    acc = acc >>> 1;
                end
                else begin
                    acc = ACC_W'(x) + ACC_W'(tap_value(ch, tap_delay_m[0]))
                        + ACC_W'(tap_value(ch, tap_delay_m[1]))
                        + ACC_W'(tap_value(ch, tap_delay_m[2]));
                    acc = acc >>> 2;
                end
                y = acc[SAMPLE_BITS-1:0];
            end
            echo_mem[ch][echo_wp[ch]] = x;
            echo_wp[ch] = echo_wp[ch] + 1'b1;
        end
        return y;
    endfunction

    // caller lowers cfg_we; back-to-back writes keep it high
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_MODE:   mode_m         = val[1:0];
            REG_BYPASS: bypass_m       = val[0];
            REG_TAP1:   tap_delay_m[0] = val[DELAY_W-1:0];
            REG_TAP2:   tap_delay_m[1] = val[DELAY_W-1:0];
            REG_TAP3:   tap_delay_m[2] = val[DELAY_W-1:0];
            default:    ;
        endcase
        cfg_writes++;
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        @(posedge clk);
        while (pending_mix.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_item(input logic ch, input sample_t smp, input logic has_want,
                             input sample_t want, input int gap);
        cfg_we <= 1'b0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        channel     <= ch;
        sample_in   <= smp;
        dir_want_on <= has_want;
        dir_want    <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // receiver: random stalls, with long stretches of steady ready
    always @(posedge clk)
    begin : rx_pace
        int g;
        if (rx_hold > 0)
            rx_hold = rx_hold - 1;
        else begin
            g = pick_gap();
            if (g > 0) begin
                out_ready <= 1'b0;
                rx_hold = g - 1;
            end
            else begin
                out_ready <= 1'b1;
                rx_hold = ($urandom_range(19) == 0) ? $urandom_range(300, 100)
                                                    : $urandom_range(6, 0);
            end
        end
    end

    always @(posedge clk)
    begin : mix_monitor
        sample_t want;
        logic    moved;
        moved = 1'b0;
        if (in_valid && in_ready) begin
            moved = 1'b1;
            mode_hits[mode_m]++;
            if (bypass_m && (mode_m == MODE_MIX1 || mode_m == MODE_MIX3))
                bypass_fed++;
            want = mixed_sample(channel, sample_in);
            pending_mix.push_back(dir_want_on ? dir_want : want);
        end
        if (out_valid && out_ready) begin
            moved = 1'b1;
            results_seen++;
            if (pending_mix.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: sample_out %0d arrived with no request pending",
                             $realtime, sample_out);
            end
            else begin
                want = pending_mix.pop_front();
                if (sample_out !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result %0d sample_out got %0d (%h) want %0d (%h)",
                                 $realtime, results_seen, sample_out, sample_out,
                                 want, want);
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("watchdog: nothing moved for %0d cycles, %0d results pending",
                 STALL_LIMIT, pending_mix.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int  row;
        int  n_items;
        int  r;
        bit  tx_calm;
        mode_m   = MODE_PASS;
        bypass_m = 1'b0;
        for (int k = 0; k < 3; k++)
            tap_delay_m[k] = DELAY_W'(1);
        for (int c = 0; c < CHANNELS; c++) begin
            echo_wp[c] = '0;
            for (int s = 0; s < DELAY_DEPTH; s++)
                echo_mem[c][s] = '0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIR_ROWS; row++) begin
            if (dir_tab[row].kind == ROW_CFG) begin
                wait_quiet();
                reg_write(dir_tab[row].idx, dir_tab[row].val);
            end
            else begin
                send_item(dir_tab[row].ch, dir_tab[row].smp, dir_tab[row].has_want,
                          dir_tab[row].want, pick_gap());
                dir_items++;
            end
        end

        // random phases: new settings, then a burst of requests
        while (rand_sent < RAND_ITEMS) begin
            wait_quiet();
            r = $urandom_range(99);
            reg_write(REG_MODE, (r < 10) ? CFG_W'(MODE_PASS) :
                                (r < 45) ? CFG_W'(MODE_MIX1) :
                                (r < 90) ? CFG_W'(MODE_MIX3) : CFG_W'(MODE_SPARE));
            reg_write(REG_BYPASS, CFG_W'($urandom_range(99) < 15));
            reg_write(REG_TAP1, pick_delay());
            reg_write(REG_TAP2, pick_delay());
            reg_write(REG_TAP3, pick_delay());
            n_items = $urandom_range(100, 20);
            tx_calm = ($urandom_range(3) == 0);
            for (int i = 0; i < n_items; i++) begin
                send_item(1'($urandom_range(1)), pick_sample(), 1'b0, '0,
                          tx_calm ? 0 : pick_gap());
                rand_sent++;
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d requests (%0d directed), %0d register writes, %0d results checked",
                 dir_items + rand_sent, dir_items, cfg_writes, results_seen);
        $display("Modes: pass %0d, single-tap %0d, three-tap %0d, spare %0d; bypass-fed %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], bypass_fed);
        if (mismatches == 0 && pending_mix.size() == 0)
            $display("PASSED: all results match");
        else begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     pending_mix.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[sim.f]
design/mtdm_pkg.sv
design/mtdm_front.sv
design/mtdm_fifo.sv
design/mtdm_back.sv
design/multi_tap_delay_mixer_top.sv
tb/tb_top.sv
